FILE: rtl/ipsv_pkg.sv
package ipsv_pkg;

  // PWM period in timer counts
  localparam int unsigned PERIOD_COUNTS = 4096;
  localparam int PW = $clog2(PERIOD_COUNTS + 1);

  localparam int VW = 16;
  localparam int PRODW = 2 * VW;
  localparam int ROTW = VW + 2;
  localparam int SCALE_W = 8;
  localparam int SCPW = ROTW + SCALE_W;
  localparam int SCW = ROTW;
  localparam int PHW = ROTW + 1;
  localparam int XW = 17;
  localparam int TPW = XW + PW;
  localparam int Q15_SHIFT = 15;
  localparam int SCALE_SHIFT = 7;
  localparam int T1W = XW + PW - Q15_SHIFT;
  localparam int SW = T1W + 3;
  localparam int CMP_W = 13;
  localparam int SEC_W = 3;

  localparam logic signed [SCALE_W-1:0] SCALE_111 = 8'sd111;
  localparam logic [PW-1:0] PERIOD_U = PW'(PERIOD_COUNTS);
  localparam logic signed [SW-1:0] PERIOD_S = SW'(PERIOD_COUNTS);

  localparam logic [SEC_W-1:0] SECTOR_0 = 3'd0;
  localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SEC_W-1:0] SECTOR_5 = 3'd5;

  typedef logic signed [VW-1:0] q15_t;

  // which of the three switching times drives a leg
  typedef enum logic [1:0] {
    LEG_TA,
    LEG_TB,
    LEG_TC
  } leg_t;

  typedef struct packed {
    q15_t volt_d;
    q15_t volt_q;
    q15_t angle_sine;
    q15_t angle_cosine;
  } cmd_t;

  typedef struct packed {
    logic signed [ROTW-1:0] alpha;
    logic signed [ROTW-1:0] beta;
  } rot_t;

  typedef struct packed {
    logic [XW-1:0]    x;
    logic [XW-1:0]    y;
    logic [SEC_W-1:0] sector;
    leg_t             leg_one;
    leg_t             leg_two;
    leg_t             leg_three;
  } sel_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_one;
    logic [CMP_W-1:0] compare_two;
    logic [CMP_W-1:0] compare_three;
    logic [SEC_W-1:0] sector_index;
    logic             overmodulated;
  } pwm_t;

  function automatic logic [CMP_W-1:0] clamp_cmp(input logic signed [SW-1:0] t);
    logic signed [SW-1:0] c;
    if (t < 0) begin
      c = '0;
    end else if (t > PERIOD_S) begin
      c = PERIOD_S;
    end else begin
      c = t;
    end
    return c[CMP_W-1:0];
  endfunction

endpackage

FILE: rtl/ipsv_if.sv
interface ipsv_cmd_if;
  logic             valid;
  logic             ready;
  ipsv_pkg::q15_t   volt_d;
  ipsv_pkg::q15_t   volt_q;
  ipsv_pkg::q15_t   angle_sine;
  ipsv_pkg::q15_t   angle_cosine;

  modport source (output valid, volt_d, volt_q, angle_sine, angle_cosine, input ready);
  modport sink (input valid, volt_d, volt_q, angle_sine, angle_cosine, output ready);
endinterface

interface ipsv_pwm_if;
  logic                            valid;
  logic                            ready;
  logic [ipsv_pkg::CMP_W-1:0]      compare_one;
  logic [ipsv_pkg::CMP_W-1:0]      compare_two;
  logic [ipsv_pkg::CMP_W-1:0]      compare_three;
  logic [ipsv_pkg::SEC_W-1:0]      sector_index;
  logic                            overmodulated;

  modport source (output valid, compare_one, compare_two, compare_three, sector_index,
                  overmodulated, input ready);
  modport sink (input valid, compare_one, compare_two, compare_three, sector_index,
                overmodulated, output ready);
endinterface

FILE: rtl/inverse_park_svpwm_modulator_core.sv
// Channel   | Dir | Payload                                              | Handshake
// command   | in  | volt_d, volt_q, angle_sine, angle_cosine (Q15)       | valid/ready
// result    | out | compare_one/two/three, sector_index, overmodulated   | valid/ready
//
// One item enters per cycle unless a stalled result has filled every stage.
// The six stages are: four 16x16 products, alpha/beta sums, the 111/128 multiply,
// sector decision, period scaling multiply, switching times with clamp and leg order.
// Each stage holds its own valid bit and advances when the next stage is free, so a
// stalled result only backs up the pipeline until bubbles are squeezed out.
// Synchronous active-high reset clears the valid bits only; no state beyond the pipeline.
module inverse_park_svpwm_modulator_core (
  input  logic             clk,
  input  logic             rst,
  ipsv_cmd_if.sink         command,
  ipsv_pwm_if.source       result
);

  // Command payload gathered into one struct for the first stage
  ipsv_pkg::cmd_t cmd_data;
  ipsv_pkg::rot_t rot_data;
  ipsv_pkg::sel_t sel_data;
  ipsv_pkg::pwm_t pwm_data;

  logic rot_valid, rot_ready;
  logic sel_valid, sel_ready;

  assign cmd_data.volt_d = command.volt_d;
  assign cmd_data.volt_q = command.volt_q;
  assign cmd_data.angle_sine = command.angle_sine;
  assign cmd_data.angle_cosine = command.angle_cosine;

  // Rotate back to the stationary frame
  ipsv_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (command.valid),
    .in_ready  (command.ready),
    .in_data   (cmd_data),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  // Phase voltages and sector
  ipsv_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_data   (rot_data),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_data  (sel_data)
  );

  // Active times, compare values; its last register is the output register
  ipsv_timing u_timing (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_data   (sel_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (pwm_data)
  );

  assign result.compare_one = pwm_data.compare_one;
  assign result.compare_two = pwm_data.compare_two;
  assign result.compare_three = pwm_data.compare_three;
  assign result.sector_index = pwm_data.sector_index;
  assign result.overmodulated = pwm_data.overmodulated;

  // Commands are refused only when every stage is full and the result is stalled
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !command.ready |-> (result.valid && !result.ready))
    else $error("command refused while pipeline has room");

  // Sector stays within the six sectors
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.sector_index <= ipsv_pkg::SECTOR_5))
    else $error("sector index out of range");

  // Clamp keeps every compare within the period
  a_compare_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((32'(result.compare_one) <= ipsv_pkg::PERIOD_COUNTS)
                   && (32'(result.compare_two) <= ipsv_pkg::PERIOD_COUNTS)
                   && (32'(result.compare_three) <= ipsv_pkg::PERIOD_COUNTS)))
    else $error("compare value beyond period");

endmodule

FILE: rtl/ipsv_rotate.sv
// Inverse Park: four products, then alpha/beta sums
module ipsv_rotate (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipsv_pkg::cmd_t      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipsv_pkg::rot_t      out_data
);

  logic s1_valid, s1_ready, s2_ready;
  logic signed [ipsv_pkg::PRODW-1:0] p_dc, p_qs, p_ds, p_qc;
  ipsv_pkg::rot_t rot_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      p_dc <= in_data.volt_d * in_data.angle_cosine;
      p_qs <= in_data.volt_q * in_data.angle_sine;
      p_ds <= in_data.volt_d * in_data.angle_sine;
      p_qc <= in_data.volt_q * in_data.angle_cosine;
    end
  end

  always_comb begin
    rot_next.alpha = ipsv_pkg::ROTW'(p_dc >>> ipsv_pkg::Q15_SHIFT)
                   - ipsv_pkg::ROTW'(p_qs >>> ipsv_pkg::Q15_SHIFT);
    rot_next.beta  = ipsv_pkg::ROTW'(p_ds >>> ipsv_pkg::Q15_SHIFT)
                   + ipsv_pkg::ROTW'(p_qc >>> ipsv_pkg::Q15_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) out_data <= rot_next;
  end

endmodule

FILE: rtl/ipsv_sector.sv
// Phase voltages, sector decision and choice of the two active voltages
module ipsv_sector (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipsv_pkg::rot_t      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipsv_pkg::sel_t      out_data
);

  logic s1_valid, s1_ready, s2_ready;
  logic signed [ipsv_pkg::SCPW-1:0] sc_prod;
  logic signed [ipsv_pkg::SCW-1:0]  sc;
  logic signed [ipsv_pkg::ROTW-1:0] beta;
  logic signed [ipsv_pkg::PHW-1:0]  half, va, vb, vc, xs, ys;
  ipsv_pkg::sel_t sel_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign sc_prod = in_data.alpha * ipsv_pkg::SCALE_111;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      sc <= ipsv_pkg::SCW'(sc_prod >>> ipsv_pkg::SCALE_SHIFT);
      beta <= in_data.beta;
    end
  end

  assign half = (-ipsv_pkg::PHW'(beta)) >>> 1;
  assign va = ipsv_pkg::PHW'(beta);
  assign vb = half + ipsv_pkg::PHW'(sc);
  assign vc = half - ipsv_pkg::PHW'(sc);

  always_comb begin
    sel_next = '0;
    xs = '0;
    ys = '0;
    if (va >= 0) begin
      if (vb >= 0) begin
        sel_next.sector = ipsv_pkg::SECTOR_2;
        xs = va;
        ys = vb;
        sel_next.leg_one = ipsv_pkg::LEG_TA;
        sel_next.leg_two = ipsv_pkg::LEG_TB;
        sel_next.leg_three = ipsv_pkg::LEG_TC;
      end else if (vc >= 0) begin
        sel_next.sector = ipsv_pkg::SECTOR_4;
        xs = vc;
        ys = va;
        sel_next.leg_one = ipsv_pkg::LEG_TC;
        sel_next.leg_two = ipsv_pkg::LEG_TA;
        sel_next.leg_three = ipsv_pkg::LEG_TB;
      end else begin
        sel_next.sector = ipsv_pkg::SECTOR_0;
        xs = -vc;
        ys = -vb;
        sel_next.leg_one = ipsv_pkg::LEG_TB;
        sel_next.leg_two = ipsv_pkg::LEG_TA;
        sel_next.leg_three = ipsv_pkg::LEG_TC;
      end
    end else begin
      if (vb >= 0) begin
        if (vc >= 0) begin
          sel_next.sector = ipsv_pkg::SECTOR_5;
          xs = vb;
          ys = vc;
          sel_next.leg_one = ipsv_pkg::LEG_TB;
          sel_next.leg_two = ipsv_pkg::LEG_TC;
          sel_next.leg_three = ipsv_pkg::LEG_TA;
        end else begin
          sel_next.sector = ipsv_pkg::SECTOR_1;
          xs = -va;
          ys = -vc;
          sel_next.leg_one = ipsv_pkg::LEG_TA;
          sel_next.leg_two = ipsv_pkg::LEG_TC;
          sel_next.leg_three = ipsv_pkg::LEG_TB;
        end
      end else begin
        sel_next.sector = ipsv_pkg::SECTOR_3;
        xs = -vb;
        ys = -va;
        sel_next.leg_one = ipsv_pkg::LEG_TC;
        sel_next.leg_two = ipsv_pkg::LEG_TB;
        sel_next.leg_three = ipsv_pkg::LEG_TA;
      end
    end
    // both picks are nonnegative and below 2^XW
    sel_next.x = xs[ipsv_pkg::XW-1:0];
    sel_next.y = ys[ipsv_pkg::XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) out_data <= sel_next;
  end

endmodule

FILE: rtl/ipsv_timing.sv
// Active times scaled by the period, switching times, clamp and leg order
module ipsv_timing (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipsv_pkg::sel_t      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipsv_pkg::pwm_t      out_data
);

  logic s1_valid, s1_ready, s2_ready;
  logic [ipsv_pkg::TPW-1:0] t1_prod, t2_prod;
  logic [ipsv_pkg::T1W-1:0] t1, t2;
  logic [ipsv_pkg::SEC_W-1:0] sector;
  ipsv_pkg::leg_t leg_one, leg_two, leg_three;
  logic signed [ipsv_pkg::SW-1:0] t1_s, t2_s, tc, tb, ta;
  logic [ipsv_pkg::CMP_W-1:0] ca, cb, cc;
  ipsv_pkg::pwm_t pwm_next;

  function automatic logic [ipsv_pkg::CMP_W-1:0] pick(
    input ipsv_pkg::leg_t leg,
    input logic [ipsv_pkg::CMP_W-1:0] a,
    input logic [ipsv_pkg::CMP_W-1:0] b,
    input logic [ipsv_pkg::CMP_W-1:0] c
  );
    logic [ipsv_pkg::CMP_W-1:0] r;
    unique case (leg)
      ipsv_pkg::LEG_TA: r = a;
      ipsv_pkg::LEG_TB: r = b;
      default:          r = c;
    endcase
    return r;
  endfunction

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign t1_prod = ipsv_pkg::TPW'(ipsv_pkg::PERIOD_U) * ipsv_pkg::TPW'(in_data.x);
  assign t2_prod = ipsv_pkg::TPW'(ipsv_pkg::PERIOD_U) * ipsv_pkg::TPW'(in_data.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      t1 <= t1_prod[ipsv_pkg::TPW-1:ipsv_pkg::Q15_SHIFT];
      t2 <= t2_prod[ipsv_pkg::TPW-1:ipsv_pkg::Q15_SHIFT];
      sector <= in_data.sector;
      leg_one <= in_data.leg_one;
      leg_two <= in_data.leg_two;
      leg_three <= in_data.leg_three;
    end
  end

  assign t1_s = $signed(ipsv_pkg::SW'(t1));
  assign t2_s = $signed(ipsv_pkg::SW'(t2));
  assign tc = (ipsv_pkg::PERIOD_S - t1_s - t2_s) >>> 1;
  assign tb = tc + t1_s;
  assign ta = tb + t2_s;

  assign ca = ipsv_pkg::clamp_cmp(ta);
  assign cb = ipsv_pkg::clamp_cmp(tb);
  assign cc = ipsv_pkg::clamp_cmp(tc);

  always_comb begin
    pwm_next.compare_one = pick(leg_one, ca, cb, cc);
    pwm_next.compare_two = pick(leg_two, ca, cb, cc);
    pwm_next.compare_three = pick(leg_three, ca, cb, cc);
    pwm_next.sector_index = sector;
    pwm_next.overmodulated = (t1_s + t2_s) > ipsv_pkg::PERIOD_S;
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) out_data <= pwm_next;
  end

endmodule

FILE: sim/svpwm_checker.sv
module svpwm_checker
  import ipsv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ipsv_cmd_if  command,
  ipsv_pwm_if  result,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  pwm_t expected_pwm[$];
  pwm_t want;

  function automatic logic [CMP_W-1:0] clamp_count(input longint t);
    longint c;
    if (t < 0) begin
      c = 0;
    end else if (t > longint'(PERIOD_COUNTS)) begin
      c = longint'(PERIOD_COUNTS);
    end else begin
      c = t;
    end
    return c[CMP_W-1:0];
  endfunction

  // Inverse Park rotation, phase voltages, sector pick and switching times.
  function automatic pwm_t predict_pwm(input q15_t d, input q15_t q, input q15_t s,
                                       input q15_t c);
    longint alpha, beta, half, scaled, va, vb, vc, x, y, t1, t2, period;
    longint times [3];
    leg_t leg1, leg2, leg3;
    logic [SEC_W-1:0] sec;
    pwm_t p;
    period = longint'(PERIOD_COUNTS);
    alpha = ((longint'(d) * longint'(c)) >>> Q15_SHIFT)
          - ((longint'(q) * longint'(s)) >>> Q15_SHIFT);
    beta  = ((longint'(d) * longint'(s)) >>> Q15_SHIFT)
          + ((longint'(q) * longint'(c)) >>> Q15_SHIFT);
    half   = (-beta) >>> 1;
    scaled = (alpha * 111) >>> SCALE_SHIFT;
    va = beta;
    vb = half + scaled;
    vc = half - scaled;
    if (va >= 0) begin
      if (vb >= 0) begin
        sec = SECTOR_2; x = va; y = vb; leg1 = LEG_TA; leg2 = LEG_TB; leg3 = LEG_TC;
      end else if (vc >= 0) begin
        sec = SECTOR_4; x = vc; y = va; leg1 = LEG_TC; leg2 = LEG_TA; leg3 = LEG_TB;
      end else begin
        sec = SECTOR_0; x = -vc; y = -vb; leg1 = LEG_TB; leg2 = LEG_TA; leg3 = LEG_TC;
      end
    end else if (vb >= 0) begin
      if (vc >= 0) begin
        sec = SECTOR_5; x = vb; y = vc; leg1 = LEG_TB; leg2 = LEG_TC; leg3 = LEG_TA;
      end else begin
        sec = SECTOR_1; x = -va; y = -vc; leg1 = LEG_TA; leg2 = LEG_TC; leg3 = LEG_TB;
      end
    end else begin
      sec = SECTOR_3; x = -vb; y = -va; leg1 = LEG_TC; leg2 = LEG_TB; leg3 = LEG_TA;
    end
    t1 = (period * x) >>> Q15_SHIFT;
    t2 = (period * y) >>> Q15_SHIFT;
    times[LEG_TC] = (period - t1 - t2) >>> 1;
    times[LEG_TB] = times[LEG_TC] + t1;
    times[LEG_TA] = times[LEG_TB] + t2;
    p.compare_one   = clamp_count(times[leg1]);
    p.compare_two   = clamp_count(times[leg2]);
    p.compare_three = clamp_count(times[leg3]);
    p.sector_index  = sec;
    p.overmodulated = (t1 + t2) > period;
    return p;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               got_val);
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_pwm.delete();
    end else begin
      if (command.valid && command.ready) begin
        expected_pwm.push_back(predict_pwm(command.volt_d, command.volt_q,
                                           command.angle_sine, command.angle_cosine));
      end
      if (result.valid && result.ready) begin
        if (expected_pwm.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d",
                   $time, result.compare_one, result.compare_two, result.compare_three,
                   result.sector_index, result.overmodulated);
        end else begin
          want = expected_pwm.pop_front();
          check_field("compare_one", want.compare_one, result.compare_one);
          check_field("compare_two", want.compare_two, result.compare_two);
          check_field("compare_three", want.compare_three, result.compare_three);
          check_field("sector_index", want.sector_index, result.sector_index);
          check_field("overmodulated", want.overmodulated, result.overmodulated);
        end
      end
    end
    pending = expected_pwm.size();
  end

endmodule

FILE: sim/tb.sv
module tb;
  import ipsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_EVERY  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_idle = 1'b0;   // while set, neither side inserts gaps
  int   fail_count;
  int   pending;

  ipsv_cmd_if command_ch();
  ipsv_pwm_if result_ch();

  inverse_park_svpwm_modulator_core dut (
    .clk     (clk),
    .rst     (rst),
    .command (command_ch),
    .result  (result_ch)
  );

  svpwm_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .command    (command_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one item at the falling edge and hold it until the core takes it.
  task automatic send_cmd(input q15_t d, input q15_t q, input q15_t s, input q15_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      command_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    command_ch.valid        = 1'b1;
    command_ch.volt_d       = d;
    command_ch.volt_q       = q;
    command_ch.angle_sine   = s;
    command_ch.angle_cosine = c;
    @(posedge clk);
    while (!command_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has been seen.
  task automatic drain_results();
    command_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic q15_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // Result side: drop ready for a random stretch, then raise it again.
  initial begin
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ch.ready = 1'b0;
      end else if (stall > 0) begin
        result_ch.ready = 1'b0;
        stall--;
      end else begin
        result_ch.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    real ang;
    int  kind;
    int  mag;
    q15_t vd, vq, sn, cs;

    command_ch.valid        = 1'b0;
    command_ch.volt_d       = '0;
    command_ch.volt_q       = '0;
    command_ch.angle_sine   = '0;
    command_ch.angle_cosine = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Mid-sector angles walk the voltage vector through all six sectors.
    send_cmd(16384, 0, 16384, 28378);
    send_cmd(16384, 0, 32767, 0);
    send_cmd(16384, 0, 16384, -28378);
    send_cmd(16384, 0, -16384, -28378);
    send_cmd(16384, 0, -32768, 0);
    send_cmd(16384, 0, -16384, 28378);
    // Zero command sits on the va = vb = 0 boundary.
    send_cmd(0, 0, 0, 32767);
    send_cmd(0, 0, 0, 0);
    // Pure quadrature drive and small magnitudes.
    send_cmd(0, 12000, 23170, 23170);
    send_cmd(1, -1, -1, 1);
    // Full-scale commands; several push the active times past the period.
    send_cmd(32767, 32767, 0, 32767);
    send_cmd(-32768, -32768, -32768, -32768);
    send_cmd(32767, -32768, 32767, -32768);
    send_cmd(-32768, 32767, -32768, 32767);
    send_cmd(32767, 32767, 32767, 32767);
    send_cmd(-32768, 0, 0, -32768);
    send_cmd(0, -32768, 32767, 0);
    send_cmd(-1, -1, -1, -1);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i != 0 && i % DRAIN_EVERY == 0) drain_results();
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // Realistic operation: unit-length angle pair, bounded command.
        ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
        sn  = q15_t'($rtoi(32767.0 * $sin(ang)));
        cs  = q15_t'($rtoi(32767.0 * $cos(ang)));
        mag = (kind < 4) ? 20000 : 32767;
        vd  = q15_t'($urandom_range(0, 2 * mag) - mag);
        vq  = q15_t'($urandom_range(0, 2 * mag) - mag);
      end else if (kind < 9) begin
        vd = q15_t'($urandom);
        vq = q15_t'($urandom);
        sn = q15_t'($urandom);
        cs = q15_t'($urandom);
      end else begin
        vd = pick_extreme();
        vq = pick_extreme();
        sn = pick_extreme();
        cs = pick_extreme();
      end
      send_cmd(vd, vq, sn, cs);
    end
    no_idle = 1'b0;

    drain_results();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
